[src/mpbr_pkg.sv]
// ----------------------------------------------------------------------------
// mpbr_pkg: shared definitions for the multi-pattern byte replacer.
// Holds the table dimensions, the action codes, the literal source code and the search table select.
// ----------------------------------------------------------------------------
package mpbr_pkg;
	// The port widths of pattern_slot, byte_position, length_value and
	// source_pattern are sized for these dimensions.
	localparam int         NUM_PATTERNS    = 4;
	localparam int         MAX_PATTERN_LEN = 8;
	localparam logic [1:0] ACT_DATA     = 2'd0;
	localparam logic [1:0] ACT_LOAD_BYTE = 2'd1;
	localparam logic [1:0] ACT_LOAD_LEN  = 2'd2;
	localparam logic [2:0] SRC_LITERAL  = 3'd4;
	localparam logic       TSEL_SEARCH  = 1'b0;
endpackage

[src/multi_pattern_byte_replace.sv]
// ----------------------------------------------------------------------------
// multi_pattern_byte_replace: streaming multi-pattern byte replacer.
// Keeps a lookahead window and, at its head, tries each search pattern one
// byte compare at a time; the leftmost, lowest-numbered match is replaced.
// ----------------------------------------------------------------------------
//  channel | direction | handshake       | payload
//  in      | input     | in_valid/stall  | action, byte_value, is_final, ...
//  out     | output    | out_valid/stall | out_byte, source_pattern, end_of_stream
//
// One beat is taken at a time; in_stall is low only while the sequencer is
// idle. A load beat is handled without leaving ST_IDLE, so loads can
// follow back to back. A data beat that needs no decision is accepted
// in ST_IDLE and inserted in ST_PRE. A decision steps past each disabled
// or too-long pattern, reads and then compares each search byte, goes to
// ST_LIT when nothing matches, emits each replacement byte and then ends
// the replacement, shifts the window, and at the end of the beat releases
// the last byte it produced. A produced byte waits in a hold register until
// the next byte or the end of the beat shows whether it closes the stream;
// while out_stall keeps the output register full, the sequencer waits.
// Reset clears the lengths, window fill and control state; the tables and
// window contents are undefined until written.
module multi_pattern_byte_replace (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] action,
	input  logic [7:0] byte_value,
	input  logic       is_final,
	input  logic [1:0] pattern_slot,
	input  logic       table_select,
	input  logic [2:0] byte_position,
	input  logic [3:0] length_value,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [2:0] source_pattern,
	output logic       end_of_stream
);
	localparam int NUM_PATTERNS    = mpbr_pkg::NUM_PATTERNS;
	localparam int MAX_PATTERN_LEN = mpbr_pkg::MAX_PATTERN_LEN;
	localparam int PW = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
	localparam int KW = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
	localparam int LW = $clog2(MAX_PATTERN_LEN + 1);
	localparam int DEPTH = NUM_PATTERNS * MAX_PATTERN_LEN;
	localparam int AW = $clog2(DEPTH);
	localparam logic [LW-1:0] MAXL = LW'(MAX_PATTERN_LEN);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PRE   = 3'd1; // insert the pending byte
	localparam logic [2:0] ST_CMP   = 3'd2; // compare one pattern byte
	localparam logic [2:0] ST_EMIT  = 3'd3; // emit one replacement byte
	localparam logic [2:0] ST_LIT   = 3'd4; // emit the head byte
	localparam logic [2:0] ST_DROP  = 3'd5; // shift the window
	localparam logic [2:0] ST_POST  = 3'd6; // pass on to insertion after a decision
	localparam logic [2:0] ST_FLUSH = 3'd7; // release the held byte

	logic [2:0]    state_q;
	logic [7:0]    search_mem [DEPTH];
	logic [7:0]    replace_mem [DEPTH];
	logic [LW-1:0] slen_q [NUM_PATTERNS];
	logic [LW-1:0] rlen_q [NUM_PATTERNS];
	logic [7:0]    win_q [MAX_PATTERN_LEN];
	logic [LW-1:0] fill_q;
	logic [7:0]    pend_q;
	logic          fin_q;
	logic          after_q; // current decision is the post-insert one
	logic [PW:0]   pat_q;   // pattern under test; NUM_PATTERNS means none
	logic [LW-1:0] k_q;     // byte index within pattern / drop count
	logic [7:0]    sb_q;    // search table byte read at the current address
	logic          sbv_q;   // sb_q belongs to the current pattern byte
	logic [7:0]    hb_q;    // produced byte held back until its successor is known
	logic [2:0]    hs_q;
	logic          hv_q;
	logic [7:0]    ob_q;
	logic [2:0]    os_q;
	logic          oe_q;
	logic          ov_q;

	logic          obuf_free;
	logic          hold_free;
	logic          out_load;
	logic          pat_live;
	logic [PW-1:0] pat_idx;
	logic [KW-1:0] k_idx;
	logic [AW-1:0] addr;

	assign obuf_free = !ov_q || !out_stall;
	assign hold_free = !hv_q || obuf_free;
	assign pat_idx   = pat_q[PW-1:0];
	assign k_idx     = k_q[KW-1:0];
	assign addr      = AW'(pat_idx) * AW'(MAX_PATTERN_LEN) + AW'(k_idx);
	assign pat_live  = (slen_q[pat_idx] != '0) && (slen_q[pat_idx] <= fill_q);

	// The held byte moves to the output register when a newer byte replaces
	// it in the hold register, or when the beat ends.
	assign out_load = hv_q && obuf_free
		&& ((state_q == ST_EMIT && k_q != rlen_q[pat_idx])
			|| state_q == ST_LIT || state_q == ST_FLUSH);

	assign in_stall       = (state_q != ST_IDLE);
	assign out_valid      = ov_q;
	assign out_byte       = ob_q;
	assign source_pattern = os_q;
	assign end_of_stream  = oe_q;

	// Table memories: one write port for loads, one registered search read.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall && action == mpbr_pkg::ACT_LOAD_BYTE
				&& 32'(pattern_slot) < NUM_PATTERNS
				&& 32'(byte_position) < MAX_PATTERN_LEN) begin
			if (table_select == mpbr_pkg::TSEL_SEARCH)
				search_mem[AW'(pattern_slot) * AW'(MAX_PATTERN_LEN)
					+ AW'(byte_position)] <= byte_value;
			else
				replace_mem[AW'(pattern_slot) * AW'(MAX_PATTERN_LEN)
					+ AW'(byte_position)] <= byte_value;
		end
		sb_q <= search_mem[addr];
	end

	// Output register. Only the byte released at the end of a final beat
	// carries end_of_stream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			ob_q <= '0;
			os_q <= '0;
			oe_q <= 1'b0;
		end else if (out_load) begin
			ov_q <= 1'b1;
			ob_q <= hb_q;
			os_q <= hs_q;
			oe_q <= (state_q == ST_FLUSH) && fin_q;
		end else if (!out_stall) begin
			ov_q <= 1'b0;
		end
	end

	// Decide whether a decision is still needed after the window change.
	function automatic logic [2:0] next_after(input logic after, input logic fin,
			input logic [LW-1:0] fill);
		logic [2:0] s;
		s = ST_FLUSH;
		if (!after)
			s = ST_POST;
		else if (fin && fill != '0)
			s = ST_CMP;
		return s;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			for (int i = 0; i < NUM_PATTERNS; i++) begin
				slen_q[i] <= '0;
				rlen_q[i] <= '0;
			end
			fin_q   <= 1'b0;
			after_q <= 1'b0;
			pat_q   <= '0;
			k_q     <= '0;
			sbv_q   <= 1'b0;
			hv_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (action == mpbr_pkg::ACT_LOAD_LEN
								&& 32'(pattern_slot) < NUM_PATTERNS) begin
							if (table_select == mpbr_pkg::TSEL_SEARCH)
								slen_q[pattern_slot[PW-1:0]] <=
									(32'(length_value) > MAX_PATTERN_LEN)
									? MAXL : LW'(length_value);
							else
								rlen_q[pattern_slot[PW-1:0]] <=
									(32'(length_value) > MAX_PATTERN_LEN)
									? MAXL : LW'(length_value);
						end else if (action == mpbr_pkg::ACT_DATA) begin
							pend_q  <= byte_value;
							fin_q   <= is_final;
							pat_q   <= '0;
							k_q     <= '0;
							after_q <= 1'b0;
							state_q <= (fill_q >= MAXL) ? ST_CMP : ST_PRE;
						end
					end
				end
				ST_PRE: begin
					// Insert the pending byte, then see whether a decision is due.
					win_q[fill_q[KW-1:0]] <= pend_q;
					fill_q  <= fill_q + 1'b1;
					after_q <= 1'b1;
					pat_q   <= '0;
					k_q     <= '0;
					if (fill_q + 1'b1 >= MAXL || (fin_q && fill_q + 1'b1 != '0))
						state_q <= ST_CMP;
					else
						state_q <= hv_q ? ST_FLUSH : ST_IDLE;
				end
				ST_POST: begin
					state_q <= ST_PRE;
				end
				ST_CMP: begin
					if (pat_q == (PW+1)'(NUM_PATTERNS)) begin
						k_q     <= '0;
						state_q <= ST_LIT;
					end else if (!pat_live) begin
						pat_q <= pat_q + 1'b1;
						k_q   <= '0;
					end else if (!sbv_q) begin
						// The table byte for this position arrives next cycle.
						sbv_q <= 1'b1;
					end else begin
						sbv_q <= 1'b0;
						if (win_q[k_idx] != sb_q) begin
							pat_q <= pat_q + 1'b1;
							k_q   <= '0;
						end else if (k_q + 1'b1 == slen_q[pat_idx]) begin
							k_q     <= '0;
							state_q <= ST_EMIT;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				ST_EMIT: begin
					if (k_q == rlen_q[pat_idx]) begin
						k_q     <= slen_q[pat_idx];
						state_q <= ST_DROP;
					end else if (hold_free) begin
						hb_q <= replace_mem[addr];
						hs_q <= 3'(pat_idx);
						hv_q <= 1'b1;
						k_q  <= k_q + 1'b1;
					end
				end
				ST_LIT: begin
					if (hold_free) begin
						hb_q    <= win_q[0];
						hs_q    <= mpbr_pkg::SRC_LITERAL;
						hv_q    <= 1'b1;
						k_q     <= LW'(1);
						state_q <= ST_DROP;
					end
				end
				ST_DROP: begin
					// Shift the window by k_q entries in one step.
					for (int i = 0; i < MAX_PATTERN_LEN; i++)
						if (i + 32'(k_q) < MAX_PATTERN_LEN)
							win_q[i] <= win_q[i + 32'(k_q)];
					fill_q  <= fill_q - k_q;
					pat_q   <= '0;
					k_q     <= '0;
					state_q <= next_after(after_q, fin_q, fill_q - k_q);
				end
				ST_FLUSH: begin
					// The held byte is the beat's last one.
					if (hold_free) begin
						hv_q    <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[test/mpbr_checker.sv]
// ----------------------------------------------------------------------------
// mpbr_checker: watches both channels of the byte replacer.
// Keeps its own copy of the pattern tables and the lookahead window, predicts
// the rewritten bytes for every accepted input beat, and compares each
// accepted output beat against the oldest predicted byte.
// ----------------------------------------------------------------------------
module mpbr_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [1:0] action,
	input  logic [7:0] byte_value,
	input  logic       is_final,
	input  logic [1:0] pattern_slot,
	input  logic       table_select,
	input  logic [2:0] byte_position,
	input  logic [3:0] length_value,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] out_byte,
	input  logic [2:0] source_pattern,
	input  logic       end_of_stream,
	output int         fail_count,
	output int         pending
);
	localparam int SLOTS   = mpbr_pkg::NUM_PATTERNS;
	localparam int PAT_LEN = mpbr_pkg::MAX_PATTERN_LEN;
	localparam int BEAT_CAP = 64;

	typedef struct packed {
		logic [7:0] data;
		logic [2:0] src;
		logic       eos;
	} rewritten_byte_t;

	rewritten_byte_t rewritten_q[$];

	logic [7:0] search_bytes [SLOTS][PAT_LEN];
	logic [7:0] subst_bytes  [SLOTS][PAT_LEN];
	logic [3:0] search_len   [SLOTS];
	logic [3:0] subst_len    [SLOTS];
	logic [7:0] window       [PAT_LEN];
	int         window_fill;
	int         made;

	task automatic push_byte(input logic [7:0] data, input logic [2:0] src);
		rewritten_byte_t r;
		if (made < BEAT_CAP) begin
			r.data = data;
			r.src  = src;
			r.eos  = 1'b0;
			rewritten_q.push_back(r);
			made++;
		end
	endtask

	task automatic drop_head(input int count);
		int c;
		c = (count > window_fill) ? window_fill : count;
		for (int i = 0; i + c < window_fill; i++)
			window[i] = window[i + c];
		window_fill -= c;
	endtask

	// Leftmost match wins; among matches at the head the lowest slot wins.
	task automatic decide_head();
		int  hit;
		bit  ok;
		hit = SLOTS;
		for (int p = 0; p < SLOTS; p++) begin
			if (hit == SLOTS && search_len[p] != 0 && search_len[p] <= window_fill) begin
				ok = 1'b1;
				for (int k = 0; k < search_len[p]; k++)
					if (window[k] != search_bytes[p][k])
						ok = 1'b0;
				if (ok)
					hit = p;
			end
		end
		if (hit < SLOTS) begin
			for (int k = 0; k < subst_len[hit]; k++)
				push_byte(subst_bytes[hit][k], 3'(hit));
			drop_head(search_len[hit]);
		end else begin
			push_byte(window[0], mpbr_pkg::SRC_LITERAL);
			drop_head(1);
		end
	endtask

	task automatic predict_beat();
		logic [3:0] l;
		made = 0;
		l = (length_value > 4'(PAT_LEN)) ? 4'(PAT_LEN) : length_value;
		case (action)
			mpbr_pkg::ACT_LOAD_BYTE: begin
				if (table_select == mpbr_pkg::TSEL_SEARCH)
					search_bytes[pattern_slot][byte_position] = byte_value;
				else
					subst_bytes[pattern_slot][byte_position] = byte_value;
			end
			mpbr_pkg::ACT_LOAD_LEN: begin
				if (table_select == mpbr_pkg::TSEL_SEARCH)
					search_len[pattern_slot] = l;
				else
					subst_len[pattern_slot] = l;
			end
			mpbr_pkg::ACT_DATA: begin
				if (window_fill >= PAT_LEN)
					decide_head();
				window[window_fill] = byte_value;
				window_fill++;
				if (window_fill >= PAT_LEN)
					decide_head();
				if (is_final) begin
					while (window_fill > 0)
						decide_head();
					if (made > 0)
						rewritten_q[$].eos = 1'b1;
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		rewritten_byte_t want;
		if (!arst_n) begin
			fail_count  <= 0;
			pending     <= 0;
			window_fill = 0;
			for (int p = 0; p < SLOTS; p++) begin
				search_len[p] = '0;
				subst_len[p]  = '0;
			end
			rewritten_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (rewritten_q.size() == 0) begin
					$display("%0t: unexpected byte: expected none actual %h/%0d/%0b",
						$time, out_byte, source_pattern, end_of_stream);
					fail_count <= fail_count + 1;
				end else begin
					want = rewritten_q.pop_front();
					if (want.data !== out_byte || want.src !== source_pattern ||
							want.eos !== end_of_stream) begin
						$display("%0t: byte mismatch: expected %h/%0d/%0b actual %h/%0d/%0b",
							$time, want.data, want.src, want.eos,
							out_byte, source_pattern, end_of_stream);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && !in_stall)
				predict_beat();
			pending <= rewritten_q.size();
		end
	end
endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the multi-pattern byte replacer.
// Fills every table entry first, runs a directed set of streams, then random
// streams over four idle and stall phases; a checker module predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
	// Action code that the block must ignore entirely.
	localparam logic [1:0] ACT_IGNORED  = 2'd3;
	localparam logic       TSEL_REPLACE = ~mpbr_pkg::TSEL_SEARCH;
	localparam int         CYCLE_LIMIT  = 2000000;
	localparam int         RANDOM_BEATS = 220;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] action;
	logic [7:0] byte_value;
	logic       is_final;
	logic [1:0] pattern_slot;
	logic       table_select;
	logic [2:0] byte_position;
	logic [3:0] length_value;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_byte;
	logic [2:0] source_pattern;
	logic       end_of_stream;
	int         fail_count;
	int         pending;
	int         cycles = 0;
	int         idle_pct;
	int         stall_pct;
	int         sent;

	multi_pattern_byte_replace i_dut (.*);

	mpbr_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost byte ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// The receiver stalls at random according to the current phase.
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	// Small alphabet so that random data actually hits the patterns.
	function automatic logic [7:0] pick_byte();
		if ($urandom_range(9) < 8)
			return 8'h61 + 8'($urandom_range(2));
		return 8'($urandom);
	endfunction

	// Drive one beat at the falling edge and hold it until it is accepted.
	// A random idle gap may precede it; valid only drops during such a gap.
	task automatic send_beat(input logic [1:0] act, input logic [7:0] val,
			input logic fin, input logic [1:0] slot, input logic sel,
			input logic [2:0] pos, input logic [3:0] len);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid      = 1'b1;
		action        = act;
		byte_value    = val;
		is_final      = fin;
		pattern_slot  = slot;
		table_select  = sel;
		byte_position = pos;
		length_value  = len;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
	endtask

	task automatic load_pattern(input logic [1:0] slot, input logic sel,
			input logic [63:0] text, input logic [3:0] len);
		for (int k = 0; k < 8; k++)
			send_beat(mpbr_pkg::ACT_LOAD_BYTE, text[63 - 8 * k -: 8], 1'b0, slot, sel,
				3'(k), '0);
		send_beat(mpbr_pkg::ACT_LOAD_LEN, '0, 1'b0, slot, sel, '0, len);
	endtask

	task automatic send_text(input logic [63:0] text, input int count, input logic fin);
		for (int k = 0; k < count; k++)
			send_beat(mpbr_pkg::ACT_DATA, text[63 - 8 * k -: 8], fin && (k == count - 1),
				'0, '0, '0, '0);
	endtask

	// Random beat content: mostly well-formed streams, some reloads and noise.
	task automatic random_beat();
		int roll;
		roll = $urandom_range(99);
		if (roll < 84)
			send_beat(mpbr_pkg::ACT_DATA, pick_byte(), ($urandom_range(15) == 0),
				2'($urandom), 1'($urandom), 3'($urandom), 4'($urandom));
		else if (roll < 92)
			send_beat(mpbr_pkg::ACT_LOAD_BYTE, pick_byte(), 1'($urandom), 2'($urandom),
				1'($urandom), 3'($urandom), 4'($urandom));
		else if (roll < 97)
			send_beat(mpbr_pkg::ACT_LOAD_LEN, 8'($urandom), 1'($urandom), 2'($urandom),
				1'($urandom), 3'($urandom), 4'($urandom_range(15)));
		else
			send_beat(ACT_IGNORED, 8'($urandom), 1'($urandom), 2'($urandom),
				1'($urandom), 3'($urandom), 4'($urandom));
	endtask

	initial begin
		sent          = 0;
		idle_pct      = 0;
		stall_pct     = 0;
		in_valid      = 1'b0;
		out_stall     = 1'b0;
		action        = mpbr_pkg::ACT_DATA;
		byte_value    = '0;
		is_final      = 1'b0;
		pattern_slot  = '0;
		table_select  = mpbr_pkg::TSEL_SEARCH;
		byte_position = '0;
		length_value  = '0;
		arst_n        = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Every table byte is written before any data, so no compare or
		// emission ever reads an unwritten entry. Slot 0 "ab" -> "XYZ",
		// slot 1 "abc" (shadowed by slot 0), slot 2 an 8-byte pattern that
		// is replaced by nothing, slot 3 disabled.
		load_pattern(2'd0, mpbr_pkg::TSEL_SEARCH, "abxxxxxx", 4'd2);
		load_pattern(2'd0, TSEL_REPLACE,          "XYZxxxxx", 4'd3);
		load_pattern(2'd1, mpbr_pkg::TSEL_SEARCH, "abcxxxxx", 4'd3);
		load_pattern(2'd1, TSEL_REPLACE,          "12345678", 4'd8);
		load_pattern(2'd2, mpbr_pkg::TSEL_SEARCH, "cccccccc", 4'd8);
		load_pattern(2'd2, TSEL_REPLACE,          "zzzzzzzz", 4'd0);
		load_pattern(2'd3, mpbr_pkg::TSEL_SEARCH, "bbbbbbbb", 4'd0);
		load_pattern(2'd3, TSEL_REPLACE,          "qqqqqqqq", 4'd15);

		// Directed streams: overlapping candidates, byte extremes, a match
		// that would run past the end, an empty replacement leaving a final
		// beat with no output, and an ignored action.
		send_text("abcabxxx", 5, 1'b1);
		send_text({8'h00, 8'hff, 8'h00, 8'hff, 32'h0}, 4, 1'b1);
		send_text("xaxxxxxx", 2, 1'b1);
		send_text("cccccccc", 8, 1'b1);
		send_beat(ACT_IGNORED, 8'hff, 1'b1, 2'd3, 1'b1, 3'd7, 4'd15);
		send_beat(mpbr_pkg::ACT_DATA, "c", 1'b0, '0, '0, '0, '0);
		send_text("cccccccc", 8, 1'b1);

		// Random part over four idle and stall phases.
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct  = (ph == 1) ? 78 : (ph == 3) ? 29 : 0;
			stall_pct = (ph == 2) ? 78 : (ph == 3) ? 29 : 0;
			for (int i = 0; i < RANDOM_BEATS / 4; i++)
				random_beat();
		end
		send_beat(mpbr_pkg::ACT_DATA, pick_byte(), 1'b1, '0, '0, '0, '0);

		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
